// File: hw/rtl/xcfp_pkg.sv
// ----------------------------------------------------------------------------
// xcfp_pkg
// Types and constants shared by the framed packet parser with XOR check.
// ----------------------------------------------------------------------------
package xcfp_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 6;
	localparam int INDEX_W = 5;

	// head, source, destination, type, length, check and tail
	localparam logic [BYTE_W-1:0] FIXED_BYTES    = 8'd7;
	localparam logic [BYTE_W-1:0] PAYLOAD_START  = 8'd5;
	localparam logic [BYTE_W-1:0] COUNT_MAX      = 8'd255;
	localparam logic [BYTE_W-1:0] HEAD_RESET     = 8'd170;
	localparam logic [BYTE_W-1:0] TAIL_RESET     = 8'd85;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL = 1'b1;

	// header byte positions
	localparam int HDR_SRC  = 0;
	localparam int HDR_DST  = 1;
	localparam int HDR_TYPE = 2;
	localparam int HDR_LEN  = 3;

	typedef enum logic [0:0] {
		KIND_STATUS  = 1'b0,
		KIND_PAYLOAD = 1'b1
	} item_kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_BAD_FRAME = 3'd2,
		ST_OVER      = 3'd3,
		ST_MISMATCH  = 3'd4,
		ST_CHECKSUM  = 3'd5
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              end_of_frame;
	} in_item_t;

	typedef struct packed {
		item_kind_t         item_kind;
		status_t            status;
		logic [BYTE_W-1:0]  source_id;
		logic [BYTE_W-1:0]  dest_id;
		logic [BYTE_W-1:0]  message_type;
		logic [LEN_W-1:0]   payload_length;
		logic [INDEX_W-1:0] payload_index;
		logic [BYTE_W-1:0]  payload_value;
		logic               run_last;
	} out_item_t;

	typedef enum logic [1:0] {
		S_RECV   = 2'd0,
		S_STATUS = 2'd1,
		S_READ   = 2'd2,
		S_EMIT   = 2'd3
	} state_t;

	typedef struct packed {
		logic take_byte;
		logic load_status;
		logic rd_en;
		logic load_payload;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic replay;
		logic rd_last;
	} dp_stat_t;

endpackage

// File: hw/rtl/xcfp_ram.sv
// ----------------------------------------------------------------------------
// xcfp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xcfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/xcfp_ctrl.sv
// ----------------------------------------------------------------------------
// xcfp_ctrl
// Controller: receives frame bytes, then issues the status result and the
// payload replay through the datapath.
// ----------------------------------------------------------------------------
module xcfp_ctrl
	import xcfp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	input  logic     end_of_frame,
	output logic     byte_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RECV;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_RECV: begin
				if (byte_valid && end_of_frame) begin
					state_d = S_STATUS;
				end
			end
			S_STATUS: begin
				if (stat.out_free) begin
					state_d = stat.replay ? S_READ : S_RECV;
				end
			end
			S_READ: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					state_d = stat.rd_last ? S_RECV : S_READ;
				end
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		byte_stall = 1'b1;
		unique case (state_q)
			S_RECV: begin
				byte_stall    = 1'b0;
				cmd.take_byte = byte_valid;
			end
			S_STATUS: begin
				cmd.load_status = stat.out_free;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
			end
			S_EMIT: begin
				cmd.load_payload = stat.out_free;
			end
		endcase
	end

endmodule

// File: hw/rtl/xcfp_dp.sv
// ----------------------------------------------------------------------------
// xcfp_dp
// Datapath: byte count, running XOR, header capture, payload store, frame
// checks and the output register.
// ----------------------------------------------------------------------------
module xcfp_dp
	import xcfp_pkg::*;
#(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_cmd_t             cmd,
	output dp_stat_t             stat,
	input  in_item_t             byte_item,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	output logic                 result_valid,
	input  logic                 result_stall,
	output out_item_t            result_item
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

	logic [BYTE_W-1:0] head_q;
	logic [BYTE_W-1:0] tail_q;
	logic [BYTE_W-1:0] count_q;
	logic [BYTE_W-1:0] xor_q;
	logic [BYTE_W-1:0] first_q;
	logic [BYTE_W-1:0] hdr_q [4];
	logic              replay_q;
	logic [LEN_W-1:0]  rep_len_q;
	logic [LEN_W-1:0]  rd_cnt_q;
	logic              out_valid_q;
	out_item_t         out_q;
	out_item_t         pend_q;

	logic [BYTE_W-1:0] rx;
	logic [BYTE_W-1:0] n_bytes;
	logic [BYTE_W-1:0] len;
	logic [BYTE_W-1:0] wr_off;
	logic              wr_en;
	logic              out_free;
	logic              rd_last;
	logic [BYTE_W-1:0] rd_data;
	status_t           st;
	out_item_t         status_item;
	out_item_t         payload_item;

	assign rx       = byte_item.rx_byte;
	assign n_bytes  = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 8'd1;
	assign len      = hdr_q[HDR_LEN];
	assign wr_off   = count_q - PAYLOAD_START;
	assign wr_en    = cmd.take_byte && (count_q >= PAYLOAD_START) && (wr_off < MAX_LEN);
	assign out_free = !out_valid_q || !result_stall;
	assign rd_last  = (rd_cnt_q + LEN_W'(1)) == rep_len_q;

	// frame checks on the final byte
	always_comb begin
		priority if (n_bytes < FIXED_BYTES) begin
			st = ST_SHORT;
		end else if (first_q != head_q || rx != tail_q) begin
			st = ST_BAD_FRAME;
		end else if (n_bytes == COUNT_MAX || len > MAX_LEN) begin
			st = ST_OVER;
		end else if ({1'b0, n_bytes} != ({1'b0, len} + {1'b0, FIXED_BYTES})) begin
			st = ST_MISMATCH;
		end else if (xor_q != '0) begin
			st = ST_CHECKSUM;
		end else begin
			st = ST_OK;
		end
	end

	always_comb begin
		status_item           = '0;
		status_item.item_kind = KIND_STATUS;
		status_item.status    = st;
		status_item.run_last  = 1'b1;
		if (st == ST_OK) begin
			status_item.source_id      = hdr_q[HDR_SRC];
			status_item.dest_id        = hdr_q[HDR_DST];
			status_item.message_type   = hdr_q[HDR_TYPE];
			status_item.payload_length = len[LEN_W-1:0];
			status_item.run_last       = (len == '0);
		end
	end

	always_comb begin
		payload_item               = '0;
		payload_item.item_kind     = KIND_PAYLOAD;
		payload_item.status        = ST_OK;
		payload_item.payload_index = rd_cnt_q[INDEX_W-1:0];
		payload_item.payload_value = rd_data;
		payload_item.run_last      = rd_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= HEAD_RESET;
			tail_q      <= TAIL_RESET;
			count_q     <= '0;
			xor_q       <= '0;
			first_q     <= '0;
			hdr_q       <= '{default: '0};
			replay_q    <= 1'b0;
			rep_len_q   <= '0;
			rd_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_HEAD: head_q <= cfg_data;
					CFG_TAIL: tail_q <= cfg_data;
				endcase
			end
			if (cmd.take_byte) begin
				if (byte_item.end_of_frame) begin
					count_q   <= '0;
					xor_q     <= '0;
					first_q   <= '0;
					hdr_q     <= '{default: '0};
					replay_q  <= (st == ST_OK) && (len != '0);
					rep_len_q <= len[LEN_W-1:0];
				end else begin
					count_q <= n_bytes;
					if (count_q != '0) begin
						xor_q <= xor_q ^ rx;
					end
					if (count_q == '0) begin
						first_q <= rx;
					end else if (count_q <= 8'd4) begin
						hdr_q[2'(count_q - 8'd1)] <= rx;
					end
				end
			end
			if (cmd.load_status) begin
				rd_cnt_q <= '0;
			end else if (cmd.load_payload) begin
				rd_cnt_q <= rd_cnt_q + LEN_W'(1);
			end
			if (cmd.load_status || cmd.load_payload) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte && byte_item.end_of_frame) begin
			pend_q <= status_item;
		end
		if (cmd.load_status) begin
			out_q <= pend_q;
		end else if (cmd.load_payload) begin
			out_q <= payload_item;
		end
	end

	xcfp_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_PAYLOAD)
	) u_payload_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_off[AW-1:0]),
		.wr_data (rx),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_cnt_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign stat.out_free = out_free;
	assign stat.replay   = replay_q;
	assign stat.rd_last  = rd_last;

	assign result_valid = out_valid_q;
	assign result_item  = out_q;

endmodule

// File: hw/rtl/xor_checked_frame_parser_top.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_parser_top
// Framed packet parser with XOR check: head, source, destination, type,
// length, payload, check, tail.
// ----------------------------------------------------------------------------
// bytes enter on byte_valid / byte_stall, one request per byte, end_of_frame
// set on the last one. non-final bytes are taken every cycle.
// on the final byte the frame is checked and one status result is registered
// in pend_q, then moved into the output register and presented on
// result_valid / result_stall; then, for a good frame, one result per payload
// byte, each read from the payload store (registered read data) and then
// loaded into the output register. byte_stall is high from the final byte
// until the last result of the frame is in the output register.
// results wait in the output register while result_stall is high; input
// bytes are still taken meanwhile, except during a frame's result run.
// head_byte and tail_byte are written via cfg_valid / cfg_ready (always ready)
// at indexes 0 and 1, by the user only while the block is idle (not enforced).
// reset clears the frame state and sets head 170, tail 85; the payload store
// is not cleared.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser_top
	import xcfp_pkg::*;
#(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  in_item_t             byte_item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output out_item_t            result_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	xcfp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.end_of_frame (byte_item.end_of_frame),
		.byte_stall   (byte_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	xcfp_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.byte_item    (byte_item),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule
